// ----- hw/rtl/psrb_pkg.sv -----
package psrb_pkg;

	// one byte of packet data
	typedef logic [7:0] byte_t;

	// item kinds
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_APPEND  = 2'd0;
	localparam kind_t KIND_DEQUEUE = 2'd1;
	localparam kind_t KIND_READ    = 2'd2;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

endpackage

// ----- hw/rtl/psrb_slot_mem.sv -----
// byte store for all slots: one write port, one registered read port
module psrb_slot_mem #(
	parameter int DEPTH  = 32768,
	parameter int ADDR_W = 15
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  psrb_pkg::byte_t       wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output psrb_pkg::byte_t       rd_data
);

	psrb_pkg::byte_t mem_q [DEPTH];
	psrb_pkg::byte_t rd_data_q;

	// read data only moves on a read, so it holds while the result waits
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/packet_slot_ring_buffer.sv -----
// Packet slot ring buffer. A ring of SLOT_COUNT slots of SLOT_BYTES bytes each.
// Append items (kind 0) carry a packet one byte per item with end_of_packet on
// the last byte; only the last byte gives a result item: ok when the packet was
// committed to the tail slot, full when the ring was full as the packet began
// (its bytes are dropped), invalid when the packet ran past SLOT_BYTES (checked
// first). A dequeue (kind 1) returns the head slot index and packet length, or
// empty. A read (kind 2) returns one stored byte by slot and offset, or invalid
// when either is out of range. Kind 3 is ignored and gives no result. Every
// result carries the occupancy after the item plus empty and full flags.
// The block takes one item per clock when the output side keeps up; a result
// passes through the input register and the result register, read data through
// the registered read port of the slot byte memory. Slot memory contents are
// not cleared at reset: bytes or lengths never written read back as garbage.
module packet_slot_ring_buffer #(
	parameter int SLOT_COUNT = 16,
	parameter int SLOT_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  in_byte,
	input  logic        end_of_packet,
	input  logic [3:0]  read_slot,
	input  logic [10:0] read_offset,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [1:0]  response_kind,
	output logic [3:0]  given_slot,
	output logic [11:0] packet_length,
	output logic [7:0]  out_byte,
	output logic [4:0]  occupancy,
	output logic        empty_flag,
	output logic        full_flag
);

	// derived widths
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int FILL_W = $clog2(SLOT_BYTES + 1);
	localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// ring state
	logic [SLOT_W-1:0]       head_q;
	logic [SLOT_W-1:0]       tail_q;
	logic [CNT_W-1:0]        held_q;
	logic [FILL_W-1:0]       fill_q;
	logic                    in_packet_q;
	psrb_pkg::status_t       fault_q;
	logic [FILL_W-1:0]       lengths_q [SLOT_COUNT];

	// input register
	logic                    valid_s1;
	psrb_pkg::kind_t         kind_s1;
	psrb_pkg::byte_t         byte_s1;
	logic                    eop_s1;
	logic [3:0]              rslot_s1;
	logic [10:0]             roff_s1;

	// result register
	logic                    valid_s2;
	psrb_pkg::status_t       status_s2;
	psrb_pkg::kind_t         kind_s2;
	logic [3:0]              slot_s2;
	logic [11:0]             len_s2;
	logic                    rd_ok_s2;
	logic [CNT_W-1:0]        held_s2;

	// per-item decode
	logic                    is_append;
	logic                    is_dequeue;
	logic                    is_read;
	logic                    has_result;
	logic                    s2_free;
	logic                    s1_go;
	logic                    fire;

	// append path
	logic                    ring_full;
	psrb_pkg::status_t       fault_start;
	logic [FILL_W-1:0]       pos_start;
	logic                    fits;
	psrb_pkg::status_t       fault_next;
	logic [FILL_W-1:0]       pos_next;
	logic                    commit;
	logic [SLOT_W-1:0]       tail_inc;
	logic [SLOT_W-1:0]       head_inc;

	// result values
	psrb_pkg::status_t       status_new;
	logic [CNT_W-1:0]        held_new;
	logic                    rd_ok;

	// memory ports
	logic                    mem_wr_en;
	logic [ADDR_W-1:0]       mem_wr_addr;
	logic                    mem_rd_en;
	logic [ADDR_W-1:0]       mem_rd_addr;
	psrb_pkg::byte_t         mem_rd_data;

	assign is_append  = (kind_s1 == psrb_pkg::KIND_APPEND);
	assign is_dequeue = (kind_s1 == psrb_pkg::KIND_DEQUEUE);
	assign is_read    = (kind_s1 == psrb_pkg::KIND_READ);
	// a non-final append byte and an unknown kind never touch the output register
	assign has_result = is_append ? eop_s1 : (is_dequeue || is_read);

	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_go    = !has_result || s2_free;
	assign fire     = valid_s1 && s1_go;
	assign in_stall = valid_s1 && !s1_go;

	// the first byte of a packet samples the full condition and resets the fill
	assign ring_full   = (held_q == CNT_W'(SLOT_COUNT));
	assign fault_start = in_packet_q ? fault_q :
		(ring_full ? psrb_pkg::ST_FULL : psrb_pkg::ST_OK);
	assign pos_start   = in_packet_q ? fill_q : '0;
	assign fits        = (pos_start < FILL_W'(SLOT_BYTES));
	// too long overrides full
	assign fault_next  = fits ? fault_start : psrb_pkg::ST_INVALID;
	assign pos_next    = fits ? (pos_start + FILL_W'(1)) : pos_start;
	assign commit      = eop_s1 && (fault_next == psrb_pkg::ST_OK);

	assign tail_inc = (tail_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : (tail_q + SLOT_W'(1));
	assign head_inc = (head_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : (head_q + SLOT_W'(1));

	assign rd_ok = (32'(rslot_s1) < SLOT_COUNT) && (32'(roff_s1) < SLOT_BYTES);

	always_comb begin
		status_new = psrb_pkg::ST_OK;
		held_new   = held_q;
		case (kind_s1)
			psrb_pkg::KIND_APPEND: begin
				status_new = fault_next;
				if (commit) begin
					held_new = held_q + CNT_W'(1);
				end
			end
			psrb_pkg::KIND_DEQUEUE: begin
				if (held_q == '0) begin
					status_new = psrb_pkg::ST_EMPTY;
				end else begin
					held_new = held_q - CNT_W'(1);
				end
			end
			psrb_pkg::KIND_READ: begin
				status_new = rd_ok ? psrb_pkg::ST_OK : psrb_pkg::ST_INVALID;
			end
			default: begin
				status_new = psrb_pkg::ST_OK;
			end
		endcase
	end

	// byte store addressing: slot base plus offset
	assign mem_wr_en   = fire && is_append && fits && (fault_start == psrb_pkg::ST_OK);
	assign mem_wr_addr = ADDR_W'(ADDR_W'(tail_q) * ADDR_W'(SLOT_BYTES) + ADDR_W'(pos_start));
	assign mem_rd_en   = fire && is_read && rd_ok;
	assign mem_rd_addr = ADDR_W'(ADDR_W'(rslot_s1) * ADDR_W'(SLOT_BYTES) + ADDR_W'(roff_s1));

	psrb_slot_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_slot_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (byte_s1),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || s1_go) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || s1_go) && in_valid) begin
			kind_s1  <= kind;
			byte_s1  <= in_byte;
			eop_s1   <= end_of_packet;
			rslot_s1 <= read_slot;
			roff_s1  <= read_offset;
		end
	end

	// ring pointers, occupancy and packet assembly state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			fill_q      <= '0;
			in_packet_q <= 1'b0;
			fault_q     <= psrb_pkg::ST_OK;
		end else if (fire) begin
			held_q <= held_new;
			if (is_append) begin
				if (eop_s1) begin
					in_packet_q <= 1'b0;
					fill_q      <= '0;
					fault_q     <= psrb_pkg::ST_OK;
					if (commit) begin
						tail_q <= tail_inc;
					end
				end else begin
					in_packet_q <= 1'b1;
					fill_q      <= pos_next;
					fault_q     <= fault_next;
				end
			end
			if (is_dequeue && (held_q != '0)) begin
				head_q <= head_inc;
			end
		end
	end

	// packet lengths, written on commit
	always_ff @(posedge clk) begin
		if (fire && is_append && commit) begin
			lengths_q[tail_q] <= pos_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1 && has_result) begin
			status_s2 <= status_new;
			kind_s2   <= kind_s1;
			held_s2   <= held_new;
			rd_ok_s2  <= is_read && rd_ok;
			if (is_dequeue && (held_q != '0)) begin
				slot_s2 <= 4'(head_q);
				len_s2  <= 12'(lengths_q[head_q]);
			end else begin
				slot_s2 <= '0;
				len_s2  <= '0;
			end
		end
	end

	assign out_valid     = valid_s2;
	assign status        = status_s2;
	assign response_kind = kind_s2;
	assign given_slot    = slot_s2;
	assign packet_length = len_s2;
	// read data comes straight from the memory's output register
	assign out_byte      = rd_ok_s2 ? mem_rd_data : '0;
	assign occupancy     = 5'(held_s2);
	assign empty_flag    = (held_s2 == '0);
	assign full_flag     = (held_s2 == CNT_W'(SLOT_COUNT));

endmodule
